// ===== rtl/nkc_pkg.sv =====
package nkc_pkg;

    localparam int MAX_DIM     = 128;
    localparam int MAX_KERNEL  = 11;
    localparam int IMG_DEPTH   = MAX_DIM * MAX_DIM;
    localparam int KER_DEPTH   = MAX_KERNEL * MAX_KERNEL;
    localparam int IMG_AW      = $clog2(IMG_DEPTH);
    localparam int KER_AW      = $clog2(KER_DEPTH);
    localparam int POS_W       = 7;
    localparam int KSZ_W       = 4;
    localparam int DIM_W       = 8;
    localparam int PIX_W       = 8;
    localparam int PROD_W      = 2 * PIX_W;
    localparam int SUM_W       = 15;
    localparam int AREA_W      = 7;
    localparam int DIVCNT_W    = 4;

    localparam logic [1:0] FUNC_KER_WR = 2'd0;
    localparam logic [1:0] FUNC_IMG_WR = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE = 2'd2;

    localparam logic [1:0] REG_KSIZE  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic start;
        logic issue;
        logic div_start;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic tap_last;
        logic pipe_busy;
        logic div_busy;
        logic out_full;
    } sts_t;

endpackage

// ===== rtl/nkc_ctrl.sv =====
module nkc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic [1:0]      s_func,
    output logic            s_ready,
    input  nkc_pkg::sts_t   sts,
    output nkc_pkg::cmd_t   cmd
);

    nkc_pkg::state_t state_reg, state_next;
    logic accept;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nkc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nkc_pkg::ST_IDLE: begin
                if (accept && s_func == nkc_pkg::FUNC_COMPUTE) state_next = nkc_pkg::ST_RUN;
            end
            nkc_pkg::ST_RUN: begin
                if (sts.tap_last) state_next = nkc_pkg::ST_DRAIN;
            end
            nkc_pkg::ST_DRAIN: begin
                if (!sts.pipe_busy) state_next = nkc_pkg::ST_DIV;
            end
            nkc_pkg::ST_DIV: begin
                if (!sts.div_busy) state_next = nkc_pkg::ST_DONE;
            end
            nkc_pkg::ST_DONE: begin
                if (!sts.out_full) state_next = nkc_pkg::ST_IDLE;
            end
            default: state_next = nkc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == nkc_pkg::ST_IDLE);
        cmd.accept    = accept;
        cmd.start     = accept && s_func == nkc_pkg::FUNC_COMPUTE;
        cmd.issue     = (state_reg == nkc_pkg::ST_RUN);
        cmd.div_start = (state_reg == nkc_pkg::ST_DRAIN) && !sts.pipe_busy;
        cmd.load_out  = (state_reg == nkc_pkg::ST_DONE) && !sts.out_full;
    end

endmodule

// ===== rtl/nkc_dp.sv =====
module nkc_dp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [7:0]                 cfg_data,
    input  logic [1:0]                 s_func,
    input  logic [nkc_pkg::POS_W-1:0]  s_row,
    input  logic [nkc_pkg::POS_W-1:0]  s_col,
    input  logic [nkc_pkg::PIX_W-1:0]  s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [nkc_pkg::PIX_W-1:0]  m_pixel_out,
    input  nkc_pkg::cmd_t              cmd,
    output nkc_pkg::sts_t              sts
);

    // configuration
    logic [nkc_pkg::KSZ_W-1:0] ksize_reg;
    logic [nkc_pkg::DIM_W-1:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ksize_reg  <= 4'd3;
            width_reg  <= 8'd100;
            height_reg <= 8'd100;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                nkc_pkg::REG_KSIZE:  ksize_reg  <= cfg_data[nkc_pkg::KSZ_W-1:0];
                nkc_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                nkc_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [nkc_pkg::KSZ_W-1:0]  keff, pivot;
    logic [nkc_pkg::DIM_W-1:0]  weff, heff;
    logic [nkc_pkg::AREA_W-1:0] area;

    always_comb begin
        if (ksize_reg == '0)
            keff = 4'd1;
        else if (ksize_reg > 4'(nkc_pkg::MAX_KERNEL))
            keff = 4'(nkc_pkg::MAX_KERNEL);
        else
            keff = ksize_reg;
        pivot = keff >> 1;
        weff  = (width_reg  > 8'(nkc_pkg::MAX_DIM)) ? 8'(nkc_pkg::MAX_DIM) : width_reg;
        heff  = (height_reg > 8'(nkc_pkg::MAX_DIM)) ? 8'(nkc_pkg::MAX_DIM) : height_reg;
        area  = 7'(keff * keff);
    end

    // stores
    logic [nkc_pkg::PIX_W-1:0] img_mem [nkc_pkg::IMG_DEPTH];
    logic [nkc_pkg::PIX_W-1:0] ker_mem [nkc_pkg::KER_DEPTH];
    logic [nkc_pkg::PIX_W-1:0] img_q, ker_q;

    logic ker_we, img_we;
    logic [nkc_pkg::KER_AW-1:0] ker_waddr;
    assign ker_we = cmd.accept && s_func == nkc_pkg::FUNC_KER_WR
                    && s_row < 7'(nkc_pkg::MAX_KERNEL) && s_col < 7'(nkc_pkg::MAX_KERNEL);
    assign img_we = cmd.accept && s_func == nkc_pkg::FUNC_IMG_WR;
    assign ker_waddr = 7'(s_row * 7'(nkc_pkg::MAX_KERNEL)) + s_col;

    // tap walk
    logic [nkc_pkg::POS_W-1:0] orow_reg, ocol_reg;
    logic [nkc_pkg::KSZ_W-1:0] kr_reg, kc_reg;
    logic signed [8:0] ty, tx;
    logic tap_in;
    logic [nkc_pkg::IMG_AW-1:0] img_raddr;
    logic [nkc_pkg::KER_AW-1:0] ker_raddr;

    always_comb begin
        ty = $signed({2'b00, orow_reg}) + $signed({5'b0, kr_reg}) - $signed({5'b0, pivot});
        tx = $signed({2'b00, ocol_reg}) + $signed({5'b0, kc_reg}) - $signed({5'b0, pivot});
        tap_in = !ty[8] && !tx[8] && (ty[7:0] < heff) && (tx[7:0] < weff);
        img_raddr = {ty[6:0], tx[6:0]};
        ker_raddr = 7'(kr_reg * 7'(nkc_pkg::MAX_KERNEL)) + {3'b0, kc_reg};
    end

    assign sts.tap_last = (kr_reg == keff - 4'd1) && (kc_reg == keff - 4'd1);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            orow_reg <= s_row;
            ocol_reg <= s_col;
            kr_reg   <= '0;
            kc_reg   <= '0;
        end else if (cmd.issue) begin
            if (kc_reg == keff - 4'd1) begin
                kc_reg <= '0;
                kr_reg <= kr_reg + 4'd1;
            end else begin
                kc_reg <= kc_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ker_we) ker_mem[ker_waddr] <= s_value;
        if (img_we) img_mem[{s_row, s_col}] <= s_value;
        img_q <= img_mem[img_raddr];
        ker_q <= ker_mem[ker_raddr];
    end

    // pipeline: read, multiply, scale and accumulate
    logic v1_reg, v2_reg, in1_reg;
    logic [nkc_pkg::PROD_W-1:0] prod_reg;
    logic [nkc_pkg::PROD_W:0]   scaled;
    logic [nkc_pkg::SUM_W-1:0]  acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        in1_reg  <= tap_in;
        prod_reg <= in1_reg ? img_q * ker_q : '0;
    end

    // exact floor(x/255) for every product of two 8-bit values
    assign scaled = ({1'b0, prod_reg} + 17'(prod_reg >> 8) + 17'd1) >> 8;

    always_ff @(posedge aclk) begin
        if (cmd.start)
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= acc_reg + scaled[nkc_pkg::SUM_W-1:0];
    end

    assign sts.pipe_busy = v1_reg || v2_reg || cmd.issue;

    // restoring divide by area
    logic [nkc_pkg::DIVCNT_W-1:0] dcnt_reg;
    logic [nkc_pkg::SUM_W-1:0]    quo_reg;
    logic [nkc_pkg::AREA_W-1:0]   rem_reg;
    logic [nkc_pkg::AREA_W:0]     shifted;
    logic [nkc_pkg::AREA_W+1:0]   diff;

    assign shifted = {rem_reg, quo_reg[nkc_pkg::SUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b0, area};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_start) begin
            dcnt_reg <= 4'(nkc_pkg::SUM_W);
        end else if (dcnt_reg != '0) begin
            dcnt_reg <= dcnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            quo_reg <= acc_reg;
            rem_reg <= '0;
        end else if (dcnt_reg != '0) begin
            rem_reg <= diff[nkc_pkg::AREA_W+1] ? shifted[nkc_pkg::AREA_W-1:0]
                                               : diff[nkc_pkg::AREA_W-1:0];
            quo_reg <= {quo_reg[nkc_pkg::SUM_W-2:0], ~diff[nkc_pkg::AREA_W+1]};
        end
    end

    assign sts.div_busy = (dcnt_reg != '0);

    // result register
    logic out_valid_reg;
    logic [nkc_pkg::PIX_W-1:0] out_pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) out_pix_reg <= quo_reg[nkc_pkg::PIX_W-1:0];
    end

    assign sts.out_full  = out_valid_reg && !m_ready;
    assign m_valid       = out_valid_reg;
    assign m_pixel_out   = out_pix_reg;

endmodule

// ===== rtl/normalized_kernel_convolution_top.sv =====
// zero-padded 2-d convolution over a stored 128 x 128 8-bit image with an up to 11 x 11
// 8-bit kernel. write items (kernel entry or image pixel) give no result; a compute item
// gives one pixel_out, the mean over the kernel area of floor(pixel*coef/255), with pixels
// outside the frame read as zero. a compute item runs the tap walk over all k*k taps (one
// read of each store and one multiply per cycle), then the pipeline drain, the bit-serial
// divide by k*k and the load of the result. the input is taken again as soon as the divide
// result is in the output register, so writes may proceed while a result waits. stores have
// no reset; read only what was written
module normalized_kernel_convolution_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration writes
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [7:0]                 cfg_data,
    // input items
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_func,
    input  logic [nkc_pkg::POS_W-1:0]  s_row,
    input  logic [nkc_pkg::POS_W-1:0]  s_col,
    input  logic [nkc_pkg::PIX_W-1:0]  s_value,
    // result items
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [nkc_pkg::PIX_W-1:0]  m_pixel_out
);

    nkc_pkg::cmd_t cmd;
    nkc_pkg::sts_t sts;

    // sequencer: idle, tap walk, drain, divide, hand over result
    nkc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // stores, tap pipeline, divider and output register
    nkc_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_func      (s_func),
        .s_row       (s_row),
        .s_col       (s_col),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .cmd         (cmd),
        .sts         (sts)
    );

    logic v_busy_q;
    assign v_busy_q = sts.pipe_busy;

    // a compute item blocks the input while it runs
    a_busy_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> !s_ready)
        else $error("input taken during compute");

    // divide only starts with the tap pipeline empty
    a_div_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !v_busy_q)
        else $error("divide started with taps in flight");

    // a result only appears from the sequencer's load
    a_out_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.load_out))
        else $error("result without load");

endmodule
